// File: design/rhp_pkg.sv
// Shared constants and types for the range histogram with peak tracking.
package rhp_pkg;
   localparam int BINS       = 256;
   localparam int BIN_W      = 8;
   localparam int CNT_W      = 32;
   localparam int DIV_STEPS  = 40;
   localparam int STEP_W     = 6;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [33:0] ONE_Q16 = 34'd65536;
   localparam logic CSR_LOW  = 1'b0;
   localparam logic CSR_HIGH = 1'b1;
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic             we;
      logic [BIN_W-1:0] waddr;
      logic [CNT_W-1:0] wdata;
      logic [BIN_W-1:0] raddr;
   } mem_req_type;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_DIVP = 8'b0000_0010,
      S_DIVX = 8'b0000_0100,
      S_RDB  = 8'b0000_1000,
      S_RDP  = 8'b0001_0000,
      S_WAIT = 8'b0010_0000,
      S_UPD  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;
endpackage

// File: design/rhp_div.sv
// Bit-serial bin index unit: low bits of floor(BINS*(x-low)/(high+1.0-low)).
module rhp_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [31:0]       x,
   input  logic signed [31:0]       low,
   input  logic signed [31:0]       high,
   output logic                     done,
   output logic [rhp_pkg::BIN_W-1:0] bin
);
   import rhp_pkg::*;

   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [32:0]             rem_ff, rem_in, den_ff, den_in;
   logic [DIV_STEPS-1:0]    dvd_ff, dvd_in;
   logic [BIN_W-1:0]        q_ff, q_in;
   logic signed [32:0]      num;
   logic signed [33:0]      den;
   logic [33:0]             trial;

   assign num   = {x[31], x} - {low[31], low};
   assign den   = {{2{high[31]}}, high} + $signed(ONE_Q16) - {{2{low[31]}}, low};
   assign trial = {rem_ff, dvd_ff[DIV_STEPS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      if (start) begin
         step_in = '0;
         rem_in  = '0;
         q_in    = '0;
         den_in  = den[32:0];
         dvd_in  = {num[31:0], {BIN_W{1'b0}}};
         if (den[33] || den == '0 || num[32]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            done_in = 1'b0;
         end
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_STEPS-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 33'(trial - {1'b0, den_ff});
            q_in   = {q_ff[BIN_W-2:0], 1'b1};
         end else begin
            rem_in = trial[32:0];
            q_in   = {q_ff[BIN_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign bin  = q_ff;

`ifndef SYNTH
   a_not_both: assert property (@(posedge clock) disable iff (reset) !(busy_ff && done_ff))
      else $error("divider busy and done together");
   a_start_clr: assert property (@(posedge clock) disable iff (reset)
      start && !done_in |=> !done_ff) else $error("done not cleared by start");
   a_step_rng: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff < STEP_W'(DIV_STEPS)) else $error("step count overran");
`endif
endmodule

// File: design/rhp_mem.sv
// Bin counter store: one write and one registered read per cycle, valid bits for reset.
module rhp_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  rhp_pkg::mem_req_type      req,
   output logic [rhp_pkg::CNT_W-1:0] rdata
);
   import rhp_pkg::*;

   logic [CNT_W-1:0] store [BINS];
   logic [BINS-1:0]  valid_ff;
   logic [CNT_W-1:0] raw_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (req.we) store[req.waddr] <= req.wdata;
      raw_ff <= store[req.raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         rvalid_ff <= valid_ff[req.raddr];
         if (req.we) valid_ff[req.waddr] <= 1'b1;
      end
   end

   assign rdata = rvalid_ff ? raw_ff : '0;
endmodule

// File: design/range_histogram_with_peak_core.sv
// Top level of the range histogram with peak tracking.
// Input beats on req_: tuser selects record (0) or read (1); tdata carries the
// sample and the bin to read. Each accepted beat yields exactly one rsp_ beat
// with the bin, its count and the current peak sample, peak bin and peak count.
// The block handles one item at a time: req_tready is high only when idle.
// The bit-serial bin unit runs one pass for the peak sample and, for records
// only, a second pass for the new sample. The block then reads the bin, reads
// the peak bin and updates the counter store and the output register.
// The result stays in the output register until rsp_tready is seen; no new
// beat is taken until then.
// Synchronous reset empties all bins at once through valid bits, clears the
// peak sample and both range registers; no clearing pass is needed.
// csr_ writes set range_low (index 0) and range_high (index 1); the user must
// issue them only while idle, and the block itself does not enforce this.
module range_histogram_with_peak_core (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // sample[31:0], read_bin[39:32]
   input  logic          req_tuser,   // operation select
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,   // bin, count, peak_sample, peak_bin, peak_count
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);
   import rhp_pkg::*;

   state_type          state_ff, state_in;
   logic signed [31:0] low_ff, high_ff, peak_ff, peak_in;
   logic               op_ff;
   logic signed [31:0] x_ff;
   logic [BIN_W-1:0]   b_ff, b_in, pb_ff, pb_in;
   logic [CNT_W-1:0]   cb_ff, cb_in, cp_ff, cp_in, newc;
   logic [111:0]       out_ff, out_in;
   logic               div_start, div_done;
   logic signed [31:0] div_x;
   logic [BIN_W-1:0]   div_bin;
   mem_req_type        mreq;
   logic [CNT_W-1:0]   mdata;
   logic               take;

   assign take = req_tvalid && req_tready;

   rhp_div u_div (.clock, .reset, .start(div_start), .x(div_x), .low(low_ff),
                  .high(high_ff), .done(div_done), .bin(div_bin));
   rhp_mem u_mem (.clock, .reset, .req(mreq), .rdata(mdata));

   assign newc = (cb_ff == CNT_MAX) ? cb_ff : cb_ff + 1'b1;

   always_comb begin
      state_in  = state_ff;
      peak_in   = peak_ff;
      b_in      = b_ff;
      pb_in     = pb_ff;
      cb_in     = cb_ff;
      cp_in     = cp_ff;
      out_in    = out_ff;
      div_start = 1'b0;
      div_x     = peak_ff;
      mreq      = '{we: 1'b0, waddr: b_ff, wdata: newc, raddr: b_ff};
      unique case (state_ff)
         S_IDLE: if (take) begin
            div_start = 1'b1;
            b_in      = req_tdata[39:32];
            state_in  = S_DIVP;
         end
         S_DIVP: if (div_done) begin
            pb_in = div_bin;
            if (op_ff == OP_RECORD) begin
               div_start = 1'b1;
               div_x     = x_ff;
               state_in  = S_DIVX;
            end else begin
               state_in = S_RDB;
            end
         end
         S_DIVX: if (div_done) begin
            b_in     = div_bin;
            state_in = S_RDB;
         end
         S_RDB: state_in = S_RDP;
         S_RDP: begin
            mreq.raddr = pb_ff;
            cb_in      = mdata;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            cp_in    = mdata;
            state_in = S_UPD;
         end
         S_UPD: begin
            if (op_ff == OP_RECORD) begin
               mreq.we = 1'b1;
               // A peak bin that is the updated bin cannot overtake itself.
               if (pb_ff == b_ff) begin
                  out_in = {newc, pb_ff, peak_ff, newc, b_ff};
               end else if (newc > cp_ff) begin
                  peak_in = x_ff;
                  out_in  = {newc, b_ff, x_ff, newc, b_ff};
               end else begin
                  out_in = {cp_ff, pb_ff, peak_ff, newc, b_ff};
               end
            end else begin
               out_in = {cp_ff, pb_ff, peak_ff, cb_ff, b_ff};
            end
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         low_ff   <= '0;
         high_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         peak_ff  <= peak_in;
         if (csr_we && csr_index == CSR_LOW)  low_ff  <= csr_wdata;
         if (csr_we && csr_index == CSR_HIGH) high_ff <= csr_wdata;
      end
      if (take) begin
         op_ff <= req_tuser;
         x_ff  <= req_tdata[31:0];
      end
      b_ff   <= b_in;
      pb_ff  <= pb_in;
      cb_ff  <= cb_in;
      cp_ff  <= cp_in;
      out_ff <= out_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = out_ff;

`ifndef SYNTH
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      take |=> !req_tready) else $error("second beat taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready)) else $error("input open while result pending");
`endif
endmodule

// File: tb/range_histogram_with_peak_core_tb.sv
// Self-checking testbench for the range histogram core with peak tracking.
module range_histogram_with_peak_core_tb;
   import rhp_pkg::*;

   typedef struct {
      logic       op;
      logic [31:0] sample;
      logic [7:0]  rbin;
   } hist_item_type;

   typedef struct {
      logic [7:0]  bin;
      logic [31:0] count;
      logic [31:0] psample;
      logic [7:0]  pbin;
      logic [31:0] pcount;
   } hist_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [39:0]   req_tdata = '0;   // sample[31:0], read_bin[39:32]
   logic          req_tuser = 1'b0; // operation select
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [111:0]  rsp_tdata;        // bin, count, peak_sample, peak_bin, peak_count
   logic          csr_we = 1'b0;
   logic          csr_index = 1'b0;
   logic [31:0]   csr_wdata = '0;

   range_histogram_with_peak_core i_dut (.*);

   always #5 clock = ~clock;

   // Model state of the block.
   logic [31:0]        bin_count_m [BINS];
   logic signed [31:0] peak_m;
   logic signed [31:0] range_low_m;
   logic signed [31:0] range_high_m;

   hist_item_type   pending_items[$];
   hist_result_type expected_results[$];
   int  mismatches = 0;
   int  results_seen = 0;
   int  records_sent = 0;
   int  reads_sent = 0;
   int  tx_wait = 0;
   int  rx_wait = 0;
   int  items_taken = 0;
   int  taken_seen = 0;
   int  rx_seen = 0;
   int  hold_at = -1;
   bit  quiet = 0;
   logic signed [31:0] hot_samples [8];

   function automatic logic [7:0] bin_of_sample(logic signed [31:0] x);
      longint den, num, q;
      den = longint'(range_high_m) + 65536 - longint'(range_low_m);
      num = longint'(x) - longint'(range_low_m);
      if (den <= 0 || num < 0) return 8'd0;
      q = (longint'(BINS) * num) / den;
      return q[7:0];
   endfunction

   function automatic hist_result_type apply_item(hist_item_type it);
      hist_result_type r;
      logic [7:0] b, pb;
      if (it.op == OP_RECORD) begin
         b = bin_of_sample(it.sample);
         if (bin_count_m[b] != CNT_MAX) bin_count_m[b] = bin_count_m[b] + 1;
         r.count = bin_count_m[b];
         pb = bin_of_sample(peak_m);
         if (bin_count_m[b] > bin_count_m[pb]) peak_m = it.sample;
      end else begin
         b = it.rbin;
         r.count = bin_count_m[b];
      end
      pb = bin_of_sample(peak_m);
      r.bin = b;
      r.psample = peak_m;
      r.pbin = pb;
      r.pcount = bin_count_m[pb];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, field, got, want);
      mismatches++;
   endtask

   // Input side: acceptance feeds the model, the driver works at the falling edge.
   always @(posedge clock) begin
      hist_item_type it;
      if (!reset && req_tvalid && req_tready) begin
         it.op = req_tuser;
         it.sample = req_tdata[31:0];
         it.rbin = req_tdata[39:32];
         expected_results.push_back(apply_item(it));
         items_taken++;
      end
   end

   always @(negedge clock) begin
      hist_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && taken_seen == items_taken) begin
         // hold the beat until it is taken
      end else begin
         taken_seen = items_taken;
         if (tx_wait > 0) begin
            tx_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_tdata <= {it.rbin, it.sample};
            req_tuser <= it.op;
            req_tvalid <= 1'b1;
            tx_wait = quiet ? 0 : $urandom_range(0, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Output side: after each accepted beat the receiver draws its stall.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_seen != results_seen) begin
            rx_seen = results_seen;
            if (results_seen == hold_at) rx_wait = 400;
            else rx_wait = quiet ? 0 : $urandom_range(0, 7);
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      hist_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected beat", 32'(rsp_tdata[7:0]), 32'd0);
         end else begin
            w = expected_results.pop_front();
            if (rsp_tdata[7:0] !== w.bin) report_mismatch("bin", rsp_tdata[7:0], w.bin);
            if (rsp_tdata[39:8] !== w.count) report_mismatch("count", rsp_tdata[39:8], w.count);
            if (rsp_tdata[71:40] !== w.psample)
               report_mismatch("peak_sample", rsp_tdata[71:40], w.psample);
            if (rsp_tdata[79:72] !== w.pbin) report_mismatch("peak_bin", rsp_tdata[79:72], w.pbin);
            if (rsp_tdata[111:80] !== w.pcount)
               report_mismatch("peak_count", rsp_tdata[111:80], w.pcount);
         end
      end
   end

   task automatic add_record(logic [31:0] s);
      hist_item_type it;
      it.op = OP_RECORD;
      it.sample = s;
      it.rbin = $urandom_range(0, 255);
      pending_items.push_back(it);
      records_sent++;
   endtask

   task automatic add_read(logic [7:0] b);
      hist_item_type it;
      it.op = OP_READ;
      it.sample = $urandom;
      it.rbin = b;
      pending_items.push_back(it);
      reads_sent++;
   endtask

   task automatic drain_block();
      while (pending_items.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_range(logic signed [31:0] lo, logic signed [31:0] hi);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_LOW;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_HIGH;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we <= 1'b0;
      range_low_m = lo;
      range_high_m = hi;
   endtask

   // Mostly samples inside the range, many on a few hot values so the peak moves.
   task automatic random_phase(int n);
      longint span, v;
      span = longint'(range_high_m) + 65536 - longint'(range_low_m);
      for (int k = 0; k < 8; k++) begin
         v = longint'(range_low_m) + ((span > 0) ? longint'($urandom) % span : 0);
         hot_samples[k] = v[31:0];
      end
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1: add_read($urandom_range(0, 255));
            2:    add_record($urandom);
            3, 4, 5: add_record(hot_samples[$urandom_range(0, 7)]);
            default: begin
               v = longint'(range_low_m) + ((span > 0) ? longint'($urandom) % span : 0);
               add_record(v[31:0]);
            end
         endcase
      end
      drain_block();
   endtask

   initial begin
      longint lo;
      for (int i = 0; i < BINS; i++) bin_count_m[i] = '0;
      peak_m = 0;
      range_low_m = 0;
      range_high_m = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset range: one whole unit split into 256 bins, wrap above it.
      add_record(32'd0);
      add_record(32'd255);
      add_record(32'd65535);
      add_record(32'd65536);
      add_record(32'hFFFF_FFFF);
      add_record(32'h7FFF_FFFF);
      add_record(32'h8000_0000);
      add_record(32'd65535);
      add_record(32'd65535);
      add_read(8'd0);
      add_read(8'd255);
      add_read(8'd7);
      drain_block();

      // Full range at both extremes.
      write_range(32'sh8000_0000, 32'sh7FFF_FFFF);
      add_record(32'h8000_0000);
      add_record(32'h7FFF_FFFF);
      add_record(32'd0);
      add_read(8'd128);
      drain_block();

      // Empty range and inverted range send everything to bin 0.
      write_range(32'sd65536, 32'sd0);
      add_record(32'd12345);
      add_record(32'hF000_0000);
      drain_block();
      write_range(32'sd100000, -32'sd100000);
      add_record(32'd5);
      add_read(8'd0);
      drain_block();

      // Random ranges; the second holds the receiver off while the sender keeps offering.
      for (int p = 0; p < 6; p++) begin
         lo = longint'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
         write_range(lo[31:0], lo[31:0] + $urandom_range(0, 32'h0040_0000));
         quiet = (p == 3);
         if (p == 1) hold_at = results_seen + 1;
         random_phase(110);
      end

      $display("Run covered %0d records and %0d reads over ten range settings,",
               records_sent, reads_sent);
      $display("including empty, inverted and full-width ranges; %0d results checked.",
               results_seen);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #8000000;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// File: sim.f
design/rhp_pkg.sv
design/rhp_div.sv
design/rhp_mem.sv
design/range_histogram_with_peak_core.sv
tb/range_histogram_with_peak_core_tb.sv
